### hw/rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared sizes, command and status codes, and the free-bit encoder of the
// slot bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int MAX_WORDS   = 16;
  localparam int WORD_BITS   = 64;
  localparam int BIT_IDX_W   = 6;
  localparam int WORD_IDX_W  = $clog2(MAX_WORDS);
  localparam int SLOT_W      = WORD_IDX_W + BIT_IDX_W;
  localparam int TOTAL_SLOTS = MAX_WORDS * WORD_BITS;
  localparam int CFG_W       = 5;
  localparam int GEN_W       = 32;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_W-1:0] WORDS_RESET = CFG_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_STALE = 2'd3
  } status_e;

  // Index of the lowest clear bit of an occupancy word (0 when none is clear)
  function automatic logic [BIT_IDX_W-1:0] lowest_free(logic [WORD_BITS-1:0] occ);
    logic [WORD_BITS-1:0] onehot;
    logic [BIT_IDX_W-1:0] idx;
    onehot = ~occ & (occ + WORD_BITS'(1));
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hw/rtl/slot_bitmap_allocator_gen.sv
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_gen
// Next-fit slot allocator over a bitmap RAM with a per-slot generation RAM.
// After reset a clearing pass zeroes both RAMs; busy is high.
// Allocate: scans up to 16 words from the search start, one occupancy RAM read
// per word, then bumps the slot's generation in S_GEN and returns it on done_o.
// With no free slot all active words are scanned and the result is ST_FULL.
// Free and check: busy in S_FREE or S_CHECK, whose result is then registered.
// Out of range, unknown command or no active words: result next cycle, no busy.
// The receiver cannot stall; done_o marks each result for one cycle.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator_gen
  import sba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [GEN_W-1:0]    generation_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_out_o,
  output logic [GEN_W-1:0]    generation_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_GEN,
    S_FREE,
    S_CHECK
  } state_e;

  state_e                state_q;
  logic [SLOT_W-1:0]     clr_q;
  logic [CFG_W-1:0]      words_q;
  logic [WORD_IDX_W-1:0] start_q;
  logic [WORD_IDX_W-1:0] w_q;
  logic [CFG_W-1:0]      rem_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [GEN_W-1:0]      gen_q;

  logic                  occ_we;
  logic [WORD_IDX_W-1:0] occ_waddr;
  logic [WORD_BITS-1:0]  occ_wdata;
  logic [WORD_IDX_W-1:0] occ_raddr;
  logic [WORD_BITS-1:0]  occ_rdata;

  logic                  gen_we;
  logic [SLOT_W-1:0]     gen_waddr;
  logic [GEN_W-1:0]      gen_wdata;
  logic [SLOT_W-1:0]     gen_raddr;
  logic [GEN_W-1:0]      gen_rdata;

  logic [CFG_W-1:0]      nw;
  logic                  slot_in_range;
  logic [WORD_IDX_W-1:0] start_word;
  logic [WORD_IDX_W-1:0] w_next;
  logic                  found;
  logic [BIT_IDX_W-1:0]  free_bit;
  logic [GEN_W-1:0]      gen_inc;
  logic [GEN_W-1:0]      gen_new;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= WORDS_RESET;
    end else if (cfg_valid_i) begin
      words_q <= cfg_data_i;
    end
  end

  // Active word count, range test and search pointers
  assign nw            = (words_q > CFG_W'(MAX_WORDS)) ? CFG_W'(MAX_WORDS) : words_q;
  assign slot_in_range = CFG_W'(slot_i[SLOT_W-1:BIT_IDX_W]) < nw;
  assign start_word    = (CFG_W'(start_q) < nw) ? start_q : '0;
  assign w_next        = ((CFG_W'(w_q) + CFG_W'(1)) == nw) ? '0 : w_q + WORD_IDX_W'(1);
  assign found         = (occ_rdata != '1);
  assign free_bit      = lowest_free(occ_rdata);

  // Generation bump, skipping zero
  assign gen_inc = gen_rdata + GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  // RAM port control
  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = w_q;
    occ_wdata = occ_rdata | (WORD_BITS'(1) << free_bit);
    occ_raddr = start_word;
    gen_we    = 1'b0;
    gen_waddr = slot_q;
    gen_wdata = gen_new;
    gen_raddr = slot_i;
    case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q[WORD_IDX_W-1:0];
        occ_wdata = '0;
        gen_we    = 1'b1;
        gen_waddr = clr_q;
        gen_wdata = '0;
      end
      S_IDLE: begin
        if (cmd_i == CMD_FREE) begin
          occ_raddr = slot_i[SLOT_W-1:BIT_IDX_W];
        end
      end
      S_SCAN: begin
        occ_raddr = w_next;
        occ_we    = found;
        gen_raddr = {w_q, free_bit};
      end
      S_GEN: begin
        gen_we = 1'b1;
      end
      S_FREE: begin
        occ_we    = 1'b1;
        occ_waddr = slot_q[SLOT_W-1:BIT_IDX_W];
        occ_wdata = occ_rdata & ~(WORD_BITS'(1) << slot_q[BIT_IDX_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      start_q <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SLOT_W'(1);
          if (clr_q == SLOT_W'(TOTAL_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            slot_q <= slot_i;
            gen_q  <= generation_i;
            case (cmd_i)
              CMD_ALLOC: begin
                if (nw == '0) begin
                  done_o           <= 1'b1;
                  status_o         <= ST_FULL;
                  slot_out_o       <= '0;
                  generation_out_o <= '0;
                end else begin
                  w_q     <= start_word;
                  rem_q   <= nw;
                  state_q <= S_SCAN;
                end
              end
              CMD_FREE: begin
                if (slot_in_range) begin
                  state_q <= S_FREE;
                end else begin
                  done_o           <= 1'b1;
                  status_o         <= ST_RANGE;
                  slot_out_o       <= slot_i;
                  generation_out_o <= '0;
                end
              end
              CMD_CHECK: begin
                if (slot_in_range) begin
                  state_q <= S_CHECK;
                end else begin
                  done_o           <= 1'b1;
                  status_o         <= ST_RANGE;
                  slot_out_o       <= slot_i;
                  generation_out_o <= '0;
                end
              end
              default: begin
                done_o           <= 1'b1;
                status_o         <= ST_RANGE;
                slot_out_o       <= slot_i;
                generation_out_o <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            start_q <= w_q;
            slot_q  <= {w_q, free_bit};
            state_q <= S_GEN;
          end else if (rem_q == CFG_W'(1)) begin
            done_o           <= 1'b1;
            status_o         <= ST_FULL;
            slot_out_o       <= '0;
            generation_out_o <= '0;
            state_q          <= S_IDLE;
          end else begin
            w_q   <= w_next;
            rem_q <= rem_q - CFG_W'(1);
          end
        end
        S_GEN: begin
          done_o           <= 1'b1;
          status_o         <= ST_OK;
          slot_out_o       <= slot_q;
          generation_out_o <= gen_new;
          state_q          <= S_IDLE;
        end
        S_FREE: begin
          done_o           <= 1'b1;
          status_o         <= ST_OK;
          slot_out_o       <= slot_q;
          generation_out_o <= '0;
          state_q          <= S_IDLE;
        end
        S_CHECK: begin
          done_o           <= 1'b1;
          status_o         <= (gen_rdata == gen_q) ? ST_OK : ST_STALE;
          slot_out_o       <= slot_q;
          generation_out_o <= gen_rdata;
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy bitmap, one word per row
  sba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WORDS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  // Per-slot generation tags
  sba_ram #(
    .WIDTH (GEN_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

`ifndef SYNTHESIS
  // The scan never runs with no words left to visit
  a_scan_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rem_q != '0))
    else $error("scan running with zero words remaining");

  // Bitmap updates outside the clearing pass touch active words only
  a_occ_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_we && (state_q != S_CLEAR)) |-> (CFG_W'(occ_waddr) < nw))
    else $error("bitmap write to an inactive word");

  // A successful allocation never hands out generation zero
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_GEN) |-> (done_o && (generation_out_o != '0)))
    else $error("allocation returned generation zero");

  // A full answer carries slot zero and generation zero
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> ((slot_out_o == '0) && (generation_out_o == '0)))
    else $error("full status with nonzero slot or generation");
`endif

endmodule

### hw/rtl/sba_ram.sv
// ----------------------------------------------------------------------------
// sba_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### test/slot_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_alloc_checker
// Watches the command, result and configuration channels of the slot bitmap
// allocator, predicts every result from its own copy of the bitmap, the search
// start and the generation store, and compares each result field by field.
// ----------------------------------------------------------------------------
module slot_alloc_checker
  import sba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [GEN_W-1:0]    gen_i,
  input  logic                done_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [SLOT_W-1:0]   slot_res_i,
  input  logic [GEN_W-1:0]    gen_res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } slot_result_t;

  logic [WORD_BITS-1:0]  occ_model [MAX_WORDS];
  logic [GEN_W-1:0]      gen_model [TOTAL_SLOTS];
  logic [WORD_IDX_W-1:0] next_word;
  logic [CFG_W-1:0]      words_cfg;
  slot_result_t          expected_q [$];

  initial mismatch_count_o = 0;

  // Print one line per wrong field and count it
  task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                 input logic [GEN_W-1:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Work out the result of one item and advance the allocator state
  task automatic resolve_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [GEN_W-1:0] gen, output slot_result_t res);
    int               nw;
    int               w;
    int               b;
    bit               found;
    logic [GEN_W-1:0] next_gen;
    nw  = (words_cfg > CFG_W'(MAX_WORDS)) ? MAX_WORDS : int'(words_cfg);
    res = '{ST_OK, slot, '0};
    case (cmd)
      CMD_ALLOC: begin
        found = 1'b0;
        // Next-fit order: start word to the top, then wrap; a stale start scans from 0
        for (int k = 0; k < nw && !found; k++) begin
          w = (int'(next_word) < nw) ? (int'(next_word) + k) % nw : k;
          if (~occ_model[w] != '0) begin
            b = 0;
            while (occ_model[w][b]) b++;
            occ_model[w][b] = 1'b1;
            next_word = WORD_IDX_W'(w);
            res.slot  = SLOT_W'(w * WORD_BITS + b);
            // Bump the generation, skipping zero on wrap
            next_gen = gen_model[res.slot] + 1'b1;
            if (next_gen == '0) next_gen = GEN_W'(1);
            gen_model[res.slot] = next_gen;
            res.gen = next_gen;
            found   = 1'b1;
          end
        end
        if (!found) res = '{ST_FULL, '0, '0};
      end
      CMD_FREE: begin
        if (int'(slot) < nw * WORD_BITS) begin
          occ_model[slot >> BIT_IDX_W][slot[BIT_IDX_W-1:0]] = 1'b0;
        end else begin
          res.status = ST_RANGE;
        end
      end
      CMD_CHECK: begin
        if (int'(slot) < nw * WORD_BITS) begin
          res.gen = gen_model[slot];
          if (res.gen != gen) res.status = ST_STALE;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: res.status = ST_RANGE;
    endcase
  endtask

  // Compare results first, then take new items and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst_ni) begin
      for (int w = 0; w < MAX_WORDS; w++) occ_model[w] = '0;
      for (int s = 0; s < TOTAL_SLOTS; s++) gen_model[s] = '0;
      next_word = '0;
      words_cfg = WORDS_RESET;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (done_i) begin
        got = '{status_e'(status_i), slot_res_i, gen_res_i};
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item pending, slot", GEN_W'(got.slot), '0);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) begin
            report_mismatch("status", GEN_W'(got.status), GEN_W'(want.status));
          end
          if (got.slot != want.slot) begin
            report_mismatch("slot_out", GEN_W'(got.slot), GEN_W'(want.slot));
          end
          if (got.gen != want.gen) report_mismatch("generation_out", got.gen, want.gen);
        end
      end
      if (start_i && !busy_i) begin
        resolve_cmd(cmd_i, slot_i, gen_i, want);
        expected_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) words_cfg = cfg_data_i;
      pending_o = expected_q.size();
    end
  end

endmodule

### test/slot_bitmap_allocator_gen_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_gen_test
// Drives directed and random allocate, free, check and unknown commands into the slot
// allocator over a series of active word counts, and leaves the checking to
// the checker instance beside the block.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator_gen_test;
  import sba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int QUIET_PHASE  = 4;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [GEN_W-1:0]    generation_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_out_o;
  logic [GEN_W-1:0]    generation_out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i;

  int               mismatch_count;
  int               pending_results;
  int               stall_cycles;
  bit               quiet;
  logic [CMD_W-1:0] issued_q [$];
  handle_t          live_q [$];
  int               phase_words [PHASES] = '{3, 1, 4, 2, 16, 0, 1, 31, 8, 2, 17, 6};

  slot_bitmap_allocator_gen dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .slot_i           (slot_i),
    .generation_i     (generation_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .generation_out_o (generation_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  slot_alloc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_i),
    .slot_i           (slot_i),
    .gen_i            (generation_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .slot_res_i       (slot_out_o),
    .gen_res_i        (generation_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort when nothing moves on any channel for too long
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Collect live slot handles from successful allocations
  always @(posedge clk_i) begin
    logic [CMD_W-1:0] issued;
    if (done_o && issued_q.size() > 0) begin
      issued = issued_q.pop_front();
      if (issued == CMD_ALLOC && status_o == ST_OK) begin
        live_q.push_back('{slot_out_o, generation_out_o});
      end
    end
  end

  // Offer one item, with an occasional gap before it; start stays high after
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [GEN_W-1:0] gen);
    if (!quiet && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= cmd;
    slot_i       <= slot;
    generation_i <= gen;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    issued_q.push_back(cmd);
  endtask

  // Drop start and hold until every pending result is back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0 || busy);
  endtask

  task automatic write_words(input logic [CFG_W-1:0] words);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= words;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly allocate and release live handles; the rest is random noise
  task automatic random_item();
    int               pick;
    int               idx;
    handle_t          h;
    logic [GEN_W-1:0] g;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_item(CMD_ALLOC, SLOT_W'($urandom), $urandom);
    end else if (pick < 75) begin
      if (live_q.size() > 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(live_q.size() - 1);
        h   = live_q[idx];
        live_q.delete(idx);
        send_item(CMD_FREE, h.slot, $urandom);
      end else begin
        send_item(CMD_FREE, SLOT_W'($urandom), $urandom);
      end
    end else if (pick < 95) begin
      if (live_q.size() > 0 && $urandom_range(99) < 75) begin
        h = live_q[$urandom_range(live_q.size() - 1)];
        case ($urandom_range(4))
          0:       g = h.gen + 1'b1;
          1:       g = $urandom;
          default: g = h.gen;
        endcase
        send_item(CMD_CHECK, h.slot, g);
      end else begin
        send_item(CMD_CHECK, SLOT_W'($urandom), $urandom);
      end
    end else begin
      send_item(CMD_UNKNOWN, SLOT_W'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_ALLOC;
    slot_i       = '0;
    generation_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full range, fresh generations, double free, unknown command
    write_words(CFG_W'(16));
    send_item(CMD_CHECK, SLOT_W'(0), '0);
    send_item(CMD_CHECK, SLOT_W'(TOTAL_SLOTS - 1), '1);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_ALLOC, '1, '1);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, SLOT_W'(1), '0);
    send_item(CMD_FREE, SLOT_W'(1), '0);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_CHECK, SLOT_W'(1), GEN_W'(2));
    send_item(CMD_CHECK, SLOT_W'(1), GEN_W'(1));
    send_item(CMD_UNKNOWN, '1, '1);
    send_item(CMD_FREE, SLOT_W'(TOTAL_SLOTS - 1), '1);

    // Directed: one word, then no words, then an oversized count
    write_words(CFG_W'(1));
    send_item(CMD_CHECK, SLOT_W'(WORD_BITS), '0);
    send_item(CMD_FREE, '1, '0);
    send_item(CMD_ALLOC, '0, '0);
    write_words(CFG_W'(0));
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, '0, '0);
    send_item(CMD_CHECK, '0, '0);
    send_item(CMD_UNKNOWN, '0, '0);
    write_words('1);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_CHECK, '1, '0);

    // Random phases; shrinking counts leave the search start past the end
    for (int p = 0; p < PHASES; p++) begin
      write_words(CFG_W'(phase_words[p]));
      quiet = (p == QUIET_PHASE);
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
